### hw/rtl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared widths, reset values, register codes and payload types of the
// row band segmenter.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 8;
  localparam int TOP_W = 12;
  localparam int HGT_W = 13;
  localparam int WID_W = 13;

  localparam int MAX_ROWS_DEF = 4096;
  localparam int MAX_COLS_DEF = 4096;

  localparam logic [CFG_W-1:0] BG_LEVEL_RST = 8'd0;
  localparam logic [CFG_W-1:0] MAX_DIFF_RST = 8'd9;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  typedef enum logic {
    REG_BG_LEVEL = 1'b0,
    REG_MAX_DIFF = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [TOP_W-1:0] band_top;
    logic [HGT_W-1:0] band_height;
    logic [WID_W-1:0] band_width;
  } band_t;

endpackage

### hw/rtl/rbs_pixel_if.sv
// ----------------------------------------------------------------------------
// rbs_pixel_if
// Pixel request channel: valid/ready handshake with gray pixel and marks.
// ----------------------------------------------------------------------------
interface rbs_pixel_if;
  logic                     valid;
  logic                     ready;
  logic [rbs_pkg::PIX_W-1:0] pixel;
  logic                     row_end;
  logic                     frame_end;

  modport source (output valid, output pixel, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel, input row_end, input frame_end,
                  output ready);
endinterface

### hw/rtl/rbs_band_if.sv
// ----------------------------------------------------------------------------
// rbs_band_if
// Band result channel: valid/ready handshake with band top, height and width.
// ----------------------------------------------------------------------------
interface rbs_band_if;
  logic                      valid;
  logic                      ready;
  logic [rbs_pkg::TOP_W-1:0] band_top;
  logic [rbs_pkg::HGT_W-1:0] band_height;
  logic [rbs_pkg::WID_W-1:0] band_width;

  modport source (output valid, output band_top, output band_height,
                  output band_width, input ready);
  modport sink   (input valid, input band_top, input band_height,
                  input band_width, output ready);
endinterface

### hw/rtl/rbs_band_tracker.sv
// ----------------------------------------------------------------------------
// rbs_band_tracker
// Per-pixel background test, row/column counters and band open/close logic.
// Produces at most one band result per processed pixel.
// ----------------------------------------------------------------------------
module rbs_band_tracker #(
  parameter int MAX_ROWS = rbs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rbs_pkg::MAX_COLS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [rbs_pkg::PIX_W-1:0] pixel_i,
  input  logic                      row_end_i,
  input  logic                      frame_end_i,
  input  logic [rbs_pkg::CFG_W-1:0] bg_level_i,
  input  logic [rbs_pkg::CFG_W-1:0] max_diff_i,
  output logic                      emit_o,
  output rbs_pkg::band_t            band_o
);

  localparam int RowW = $clog2(MAX_ROWS);
  localparam int ColW = $clog2(MAX_COLS + 1);
  localparam int HW   = (RowW + 1 > rbs_pkg::HGT_W) ? RowW + 1 : rbs_pkg::HGT_W;
  localparam int TW   = (RowW > rbs_pkg::TOP_W) ? RowW : rbs_pkg::TOP_W;
  localparam int WW   = (ColW > rbs_pkg::WID_W) ? ColW : rbs_pkg::WID_W;

  logic            in_band_q, in_band_d;
  logic [RowW-1:0] open_top_q, open_top_d;
  logic [RowW-1:0] row_idx_q, row_idx_d;
  logic [ColW-1:0] col_cnt_q, col_cnt_d;
  logic            row_obj_q, row_obj_d;

  logic [rbs_pkg::PIX_W-1:0] dev;
  logic            obj;
  logic [ColW-1:0] col_inc;
  logic            eor, open_band, close_band, in_band_after, frame_emit;
  logic [RowW-1:0] top_after;
  logic [HW-1:0]   h_raw, h_fix;
  logic [TW-1:0]   top_ext;
  logic [WW-1:0]   wid_ext;

  always_comb begin
    dev = (pixel_i >= bg_level_i) ? pixel_i - bg_level_i : bg_level_i - pixel_i;
    obj = row_obj_q | (dev > max_diff_i);
    col_inc = (col_cnt_q < ColW'(MAX_COLS)) ? col_cnt_q + ColW'(1) : col_cnt_q;
    eor = row_end_i | frame_end_i;
    open_band  = eor & obj & ~in_band_q;
    close_band = eor & ~obj & in_band_q;
    in_band_after = open_band | (in_band_q & ~close_band);
    top_after  = open_band ? row_idx_q : open_top_q;
    // a band closed by the last row is not reported again at frame end
    frame_emit = frame_end_i & in_band_after;
    emit_o = step_i & (close_band | frame_emit);

    h_raw = HW'(row_idx_q) - HW'(top_after) + (close_band ? HW'(0) : HW'(1));
    // folded rows after row index saturation can give zero
    h_fix = (h_raw == '0) ? HW'(1) : h_raw;
    top_ext = TW'(top_after);
    wid_ext = WW'(col_inc);
    band_o.band_top    = top_ext[rbs_pkg::TOP_W-1:0];
    band_o.band_height = h_fix[rbs_pkg::HGT_W-1:0];
    band_o.band_width  = wid_ext[rbs_pkg::WID_W-1:0];
  end

  always_comb begin
    in_band_d  = in_band_q;
    open_top_d = open_top_q;
    row_idx_d  = row_idx_q;
    col_cnt_d  = col_cnt_q;
    row_obj_d  = row_obj_q;
    if (step_i) begin
      priority if (frame_end_i) begin
        in_band_d  = 1'b0;
        open_top_d = '0;
        row_idx_d  = '0;
        col_cnt_d  = '0;
        row_obj_d  = 1'b0;
      end else if (row_end_i) begin
        in_band_d  = in_band_after;
        open_top_d = top_after;
        if (row_idx_q < RowW'(MAX_ROWS - 1)) begin
          row_idx_d = row_idx_q + RowW'(1);
        end
        col_cnt_d  = '0;
        row_obj_d  = 1'b0;
      end else begin
        col_cnt_d  = col_inc;
        row_obj_d  = obj;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_band_q  <= 1'b0;
      open_top_q <= '0;
      row_idx_q  <= '0;
      col_cnt_q  <= '0;
      row_obj_q  <= 1'b0;
    end else begin
      in_band_q  <= in_band_d;
      open_top_q <= open_top_d;
      row_idx_q  <= row_idx_d;
      col_cnt_q  <= col_cnt_d;
      row_obj_q  <= row_obj_d;
    end
  end

  // an open band never starts below the current row
  a_top_le_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_band_q |-> (open_top_q <= row_idx_q))
    else $error("open band top beyond current row");

  // a result only comes out at a row or frame boundary
  a_emit_on_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> (row_end_i || frame_end_i))
    else $error("band result outside row end");

  // frame end leaves every counter cleared
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && frame_end_i) |=> (!in_band_q && row_idx_q == '0 && col_cnt_q == '0))
    else $error("state not cleared after frame end");

endmodule

### hw/rtl/rbs_result_fifo.sv
// ----------------------------------------------------------------------------
// rbs_result_fifo
// Two-entry result queue; lets pixels keep flowing while a band result waits.
// ----------------------------------------------------------------------------
module rbs_result_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rbs_pkg::band_t data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output rbs_pkg::band_t data_o
);

  rbs_pkg::band_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("result queue overflow");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("result queue pointers disagree with count");

endmodule

### hw/rtl/row_band_segmenter.sv
// ----------------------------------------------------------------------------
// row_band_segmenter
// Row segmentation of a raster gray frame into bands of non-background rows.
// ----------------------------------------------------------------------------
// a band result is valid once its last pixel is registered and the result is queued
// throughput: one pixel per cycle; input stalls only while two results wait unread
// the path is an input register, one compare/count stage and a two-entry result queue
// reset clears all counters and the band state, background level 0, max diff 9
// no clearing pass after reset, first pixel can be taken in the first cycle
// ----------------------------------------------------------------------------
module row_band_segmenter #(
  parameter int MAX_ROWS = rbs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rbs_pkg::MAX_COLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rbs_pixel_if.sink                  pixel_in,
  rbs_band_if.source                 band_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbs_pkg::APB_AW-1:0] paddr,
  input  logic [rbs_pkg::APB_DW-1:0] pwdata,
  output logic [rbs_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  logic [rbs_pkg::CFG_W-1:0] bg_level_q, max_diff_q;
  rbs_pkg::cfg_reg_e         reg_sel;
  logic                      cfg_wr;

  logic                      in_vld_q;
  logic [rbs_pkg::PIX_W-1:0] pixel_q;
  logic                      row_end_q, frame_end_q;
  logic                      in_ready, step;

  logic           emit, fifo_full, fifo_valid, pop;
  rbs_pkg::band_t band_res, band_head;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = rbs_pkg::cfg_reg_e'(paddr[rbs_pkg::APB_AW-1]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    unique case (reg_sel)
      rbs_pkg::REG_BG_LEVEL: prdata = rbs_pkg::APB_DW'(bg_level_q);
      rbs_pkg::REG_MAX_DIFF: prdata = rbs_pkg::APB_DW'(max_diff_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_level_q <= rbs_pkg::BG_LEVEL_RST;
      max_diff_q <= rbs_pkg::MAX_DIFF_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        rbs_pkg::REG_BG_LEVEL: bg_level_q <= pwdata[rbs_pkg::CFG_W-1:0];
        rbs_pkg::REG_MAX_DIFF: max_diff_q <= pwdata[rbs_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // input register; drains whenever the result queue has room
  assign step     = in_vld_q & ~fifo_full;
  assign in_ready = ~in_vld_q | step;
  assign pixel_in.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && pixel_in.valid) begin
      pixel_q     <= pixel_in.pixel;
      row_end_q   <= pixel_in.row_end;
      frame_end_q <= pixel_in.frame_end;
    end
  end

  rbs_band_tracker #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pixel_i     (pixel_q),
    .row_end_i   (row_end_q),
    .frame_end_i (frame_end_q),
    .bg_level_i  (bg_level_q),
    .max_diff_i  (max_diff_q),
    .emit_o      (emit),
    .band_o      (band_res)
  );

  assign pop = fifo_valid & band_out.ready;

  rbs_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .data_i  (band_res),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .full_o  (fifo_full),
    .data_o  (band_head)
  );

  assign band_out.valid       = fifo_valid;
  assign band_out.band_top    = band_head.band_top;
  assign band_out.band_height = band_head.band_height;
  assign band_out.band_width  = band_head.band_width;

  a_height_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    band_out.valid |-> band_out.band_height != '0)
    else $error("band result with zero height");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && fifo_full) |-> !pixel_in.ready)
    else $error("pixel taken while result queue full");

  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && fifo_full) |=> in_vld_q && $stable(pixel_q))
    else $error("pending pixel lost during stall");

endmodule
